### hdl/tlca_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlca_pkg
// shared widths, item codes, controller states and table access structs
// ----------------------------------------------------------------------------
package tlca_pkg;

  localparam int NODE_W            = 10;
  localparam int COUNT_W           = 11;
  localparam int MODE_W            = 2;
  localparam int NODE_SPAN         = 1 << NODE_W;
  localparam int DEFAULT_MAX_NODES = 1024;

  // item codes
  localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BUILD = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BUILD_CHECK,
    ST_BUILD_WAIT,
    ST_QUERY_EVAL,
    ST_QUERY_CLIMB
  } state_t;

  // requests into the parent and depth tables
  typedef struct packed {
    logic              par_we;
    logic [NODE_W-1:0] par_waddr;
    logic [NODE_W-1:0] par_wdata;
    logic [NODE_W-1:0] par_raddr;
    logic              dep_we;
    logic [NODE_W-1:0] dep_waddr;
    logic [NODE_W-1:0] dep_wdata;
    logic [NODE_W-1:0] dep_raddr_a;
    logic [NODE_W-1:0] dep_raddr_b;
  } tbl_req_t;

  // registered read data, available in the cycle after the request
  typedef struct packed {
    logic [NODE_W-1:0] par_rdata;
    logic [NODE_W-1:0] dep_rdata_a;
    logic [NODE_W-1:0] dep_rdata_b;
  } tbl_rsp_t;

endpackage
`default_nettype wire

### hdl/tlca_item_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlca_item_if
// valid/ready channel carrying one load, build or query item
// ----------------------------------------------------------------------------
interface tlca_item_if;
  logic                          valid;
  logic                          ready;
  logic [tlca_pkg::MODE_W-1:0]   mode;
  logic [tlca_pkg::NODE_W-1:0]   node_a;
  logic [tlca_pkg::NODE_W-1:0]   node_b;

  modport source (output valid, output mode, output node_a, output node_b, input ready);
  modport sink   (input valid, input mode, input node_a, input node_b, output ready);
endinterface
`default_nettype wire

### hdl/tlca_result_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlca_result_if
// valid/ready channel carrying one ancestor result
// ----------------------------------------------------------------------------
interface tlca_result_if;
  logic                          valid;
  logic                          ready;
  logic [tlca_pkg::NODE_W-1:0]   ancestor;

  modport source (output valid, output ancestor, input ready);
  modport sink   (input valid, input ancestor, output ready);
endinterface
`default_nettype wire

### hdl/tree_lowest_common_ancestor.sv
// load: no result; the next item can be taken in the following cycle
// query: result registered once the nodes meet or the step bound is hit;
//   each climbing step is one parent read plus a depth read of both nodes
// build: for each node, walks up the parent chain (a check and a wait state per step)
// one item at a time; a new item is taken as soon as the controller is idle
// reset clears control state and sets node_count to 1; tables keep contents
`default_nettype none
// ----------------------------------------------------------------------------
// tree_lowest_common_ancestor
// lowest common ancestor of two nodes in a rooted tree (root is node 0),
// by climbing parent links of the deeper node until both nodes meet or a step bound is hit
// ----------------------------------------------------------------------------
module tree_lowest_common_ancestor #(
  parameter int MAX_NODES = tlca_pkg::DEFAULT_MAX_NODES
) (
  input  logic                         clk,
  input  logic                         rst,
  tlca_item_if.sink                    item,
  tlca_result_if.source                result,
  input  logic                         cfg_we,
  input  logic [tlca_pkg::COUNT_W-1:0] cfg_wdata
);

  // node ids are NODE_W bits wide, so at most NODE_SPAN entries are reachable
  localparam int TABLE_DEPTH = (MAX_NODES < tlca_pkg::NODE_SPAN) ? MAX_NODES
                                                                 : tlca_pkg::NODE_SPAN;
  // width that holds MAX_NODES as well as any node count
  localparam int RANGE_W = ($clog2(MAX_NODES + 1) > tlca_pkg::COUNT_W) ?
                           $clog2(MAX_NODES + 1) : tlca_pkg::COUNT_W;
  localparam logic [RANGE_W-1:0] MAX_W   = RANGE_W'(MAX_NODES);
  localparam logic [RANGE_W-1:0] TABLE_W = RANGE_W'(TABLE_DEPTH);
  // climbing step bound of a query
  localparam int KW = $clog2(2 * MAX_NODES + 1);
  localparam logic [KW-1:0] STEP_LIMIT = KW'(2 * MAX_NODES);

  localparam int NW = tlca_pkg::NODE_W;
  localparam int CW = tlca_pkg::COUNT_W;

  tlca_pkg::state_t   state, state_next;
  tlca_pkg::tbl_req_t tbl_req;
  tlca_pkg::tbl_rsp_t tbl_rsp;

  logic [CW-1:0] node_count;

  // query registers
  logic [NW-1:0] u, u_next, v, v_next;
  logic [KW-1:0] step_cnt, step_cnt_next;
  logic          move_u, move_u_next;

  // build registers
  logic [NW-1:0] bld_i, bld_i_next;
  logic [NW-1:0] bld_x, bld_x_next;
  logic [CW-1:0] bld_steps, bld_steps_next;

  // result register
  logic          res_valid, res_valid_next;
  logic [NW-1:0] res_node, res_node_next;

  logic          item_xfer;
  logic          out_free;
  logic [CW-1:0] n_used;
  logic [CW-1:0] n_walk;
  logic [NW-1:0] bld_last;
  logic          bld_fail;
  logic          bld_done_node;
  logic          a_ok, b_ok, u_ok, v_ok, sel_ok;
  logic [NW-1:0] du, dv;
  logic          meet, give_up;
  logic [NW-1:0] climb_node;

  tlca_tables #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_tables (
    .clk (clk),
    .req (tbl_req),
    .rsp (tbl_rsp)
  );

  // ---------------------------------------------------------------------------
  // handshake and derived quantities
  // ---------------------------------------------------------------------------
  assign item.ready      = (state == tlca_pkg::ST_IDLE);
  assign item_xfer       = item.valid && item.ready;
  assign result.valid    = res_valid;
  assign result.ancestor = res_node;
  // the result register can take a new value this cycle
  assign out_free        = !res_valid || result.ready;

  // node count in use: zero acts as one, large values clamp to MAX_NODES
  always_comb begin
    if (node_count == '0) begin
      n_used = CW'(1);
    end else if (RANGE_W'(node_count) > MAX_W) begin
      n_used = MAX_W[CW-1:0];
    end else begin
      n_used = node_count;
    end
  end

  // nodes past the table can never be queried, so the build skips them
  assign n_walk   = (RANGE_W'(n_used) > TABLE_W) ? TABLE_W[CW-1:0] : n_used;
  assign bld_last = NW'(n_walk - CW'(1));

  // chain leaves the nodes in use or runs too long: depth becomes zero
  assign bld_fail      = (CW'(bld_x) >= n_used) || (bld_steps >= n_used);
  assign bld_done_node = (bld_x == '0) || bld_fail;

  // table range checks; reads outside the table give zero
  assign a_ok   = RANGE_W'(item.node_a) < MAX_W;
  assign b_ok   = RANGE_W'(item.node_b) < MAX_W;
  assign u_ok   = RANGE_W'(u) < MAX_W;
  assign v_ok   = RANGE_W'(v) < MAX_W;
  assign sel_ok = move_u ? u_ok : v_ok;

  assign du         = u_ok ? tbl_rsp.dep_rdata_a : '0;
  assign dv         = v_ok ? tbl_rsp.dep_rdata_b : '0;
  assign meet       = (u == v);
  assign give_up    = (step_cnt == STEP_LIMIT);
  assign climb_node = sel_ok ? tbl_rsp.par_rdata : '0;

  // ---------------------------------------------------------------------------
  // next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      tlca_pkg::ST_IDLE: begin
        if (item_xfer) begin
          case (item.mode)
            tlca_pkg::MODE_BUILD: state_next = tlca_pkg::ST_BUILD_CHECK;
            tlca_pkg::MODE_QUERY: state_next = tlca_pkg::ST_QUERY_EVAL;
            default:              state_next = tlca_pkg::ST_IDLE;
          endcase
        end
      end
      tlca_pkg::ST_BUILD_CHECK: begin
        if (!bld_done_node) begin
          state_next = tlca_pkg::ST_BUILD_WAIT;
        end else if (bld_i == bld_last) begin
          state_next = tlca_pkg::ST_IDLE;
        end
      end
      tlca_pkg::ST_BUILD_WAIT: begin
        state_next = tlca_pkg::ST_BUILD_CHECK;
      end
      tlca_pkg::ST_QUERY_EVAL: begin
        if (meet || give_up) begin
          // hold here while the previous result still waits
          if (out_free) begin
            state_next = tlca_pkg::ST_IDLE;
          end
        end else begin
          state_next = tlca_pkg::ST_QUERY_CLIMB;
        end
      end
      tlca_pkg::ST_QUERY_CLIMB: begin
        state_next = tlca_pkg::ST_QUERY_EVAL;
      end
      default: state_next = tlca_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // datapath and table requests
  // ---------------------------------------------------------------------------
  always_comb begin
    u_next         = u;
    v_next         = v;
    step_cnt_next  = step_cnt;
    move_u_next    = move_u;
    bld_i_next     = bld_i;
    bld_x_next     = bld_x;
    bld_steps_next = bld_steps;
    res_valid_next = res_valid && !result.ready;
    res_node_next  = res_node;
    tbl_req        = '0;
    tbl_req.par_raddr = bld_x;

    case (state)
      tlca_pkg::ST_IDLE: begin
        if (item_xfer) begin
          case (item.mode)
            tlca_pkg::MODE_LOAD: begin
              // edge with an endpoint past the table is dropped
              if (a_ok && b_ok) begin
                tbl_req.par_we    = 1'b1;
                tbl_req.par_waddr = item.node_b;
                tbl_req.par_wdata = item.node_a;
              end
            end
            tlca_pkg::MODE_BUILD: begin
              bld_i_next     = '0;
              bld_x_next     = '0;
              bld_steps_next = '0;
            end
            tlca_pkg::MODE_QUERY: begin
              u_next        = item.node_a;
              v_next        = item.node_b;
              step_cnt_next = '0;
            end
            default: ;
          endcase
        end
      end
      tlca_pkg::ST_BUILD_CHECK: begin
        // parent read of the current chain node, used when the walk goes on
        tbl_req.par_raddr = bld_x;
        if (bld_done_node) begin
          tbl_req.dep_we    = 1'b1;
          tbl_req.dep_waddr = bld_i;
          tbl_req.dep_wdata = (bld_x == '0) ? bld_steps[NW-1:0] : '0;
          if (bld_i != bld_last) begin
            bld_i_next     = bld_i + NW'(1);
            bld_x_next     = bld_i + NW'(1);
            bld_steps_next = '0;
          end
        end
      end
      tlca_pkg::ST_BUILD_WAIT: begin
        bld_x_next     = tbl_rsp.par_rdata;
        bld_steps_next = bld_steps + CW'(1);
      end
      tlca_pkg::ST_QUERY_EVAL: begin
        if (meet || give_up) begin
          if (out_free) begin
            res_valid_next = 1'b1;
            res_node_next  = meet ? u : '0;
          end
        end else begin
          // deeper node climbs; on equal depth the second node climbs
          move_u_next       = (du > dv);
          tbl_req.par_raddr = (du > dv) ? u : v;
        end
      end
      tlca_pkg::ST_QUERY_CLIMB: begin
        if (move_u) begin
          u_next = climb_node;
        end else begin
          v_next = climb_node;
        end
        step_cnt_next = step_cnt + KW'(1);
      end
      default: ;
    endcase

    // depths of the nodes held for the next compare
    tbl_req.dep_raddr_a = u_next;
    tbl_req.dep_raddr_b = v_next;
  end

  // ---------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= tlca_pkg::ST_IDLE;
      node_count <= CW'(1);
      res_valid  <= 1'b0;
    end else begin
      state     <= state_next;
      res_valid <= res_valid_next;
      if (cfg_we) begin
        node_count <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    u         <= u_next;
    v         <= v_next;
    step_cnt  <= step_cnt_next;
    move_u    <= move_u_next;
    bld_i     <= bld_i_next;
    bld_x     <= bld_x_next;
    bld_steps <= bld_steps_next;
    res_node  <= res_node_next;
  end

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  // nodes that have met are delivered as the ancestor on the next cycle
  a_meet_result: assert property (@(posedge clk) disable iff (rst)
    (state == tlca_pkg::ST_QUERY_EVAL && u == v && out_free)
      |=> (result.valid && result.ancestor == $past(u)))
    else $error("met query not delivered as result");

  // parent writes only come from an accepted load within the table
  a_par_write: assert property (@(posedge clk) disable iff (rst)
    tbl_req.par_we |-> (item_xfer && item.mode == tlca_pkg::MODE_LOAD
                        && RANGE_W'(tbl_req.par_waddr) < MAX_W))
    else $error("stray parent table write");

  // depth writes only during the build and only for nodes in use
  a_dep_write: assert property (@(posedge clk) disable iff (rst)
    tbl_req.dep_we |-> (state == tlca_pkg::ST_BUILD_CHECK
                        && CW'(tbl_req.dep_waddr) < n_used))
    else $error("stray depth table write");

  // climbing never passes the step bound
  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    (state == tlca_pkg::ST_QUERY_CLIMB) |-> (step_cnt < STEP_LIMIT))
    else $error("query climbed past its step bound");

endmodule
`default_nettype wire

### hdl/tlca_tables.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlca_tables
// parent table (one write, one read port) and depth table (one write, two
// read ports), with synchronous registered reads
// ----------------------------------------------------------------------------
module tlca_tables #(
  parameter int TABLE_DEPTH = tlca_pkg::NODE_SPAN
) (
  input  logic               clk,
  input  tlca_pkg::tbl_req_t req,
  output tlca_pkg::tbl_rsp_t rsp
);

  localparam int AW = $clog2(TABLE_DEPTH);

  logic [tlca_pkg::NODE_W-1:0] parent_mem [TABLE_DEPTH];
  logic [tlca_pkg::NODE_W-1:0] depth_mem  [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.par_we) begin
      parent_mem[req.par_waddr[AW-1:0]] <= req.par_wdata;
    end
    if (req.dep_we) begin
      depth_mem[req.dep_waddr[AW-1:0]] <= req.dep_wdata;
    end
    rsp.par_rdata   <= parent_mem[req.par_raddr[AW-1:0]];
    rsp.dep_rdata_a <= depth_mem[req.dep_raddr_a[AW-1:0]];
    rsp.dep_rdata_b <= depth_mem[req.dep_raddr_b[AW-1:0]];
  end

endmodule
`default_nettype wire

### verif/tree_lowest_common_ancestor_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tree_lowest_common_ancestor_tb
// drives load, build and query transfers into the ancestor block, predicts
// each ancestor with an independent table model and checks every result
// in order, with random idling on both channels and a long output stall
// ----------------------------------------------------------------------------
module tree_lowest_common_ancestor_tb;

  localparam int CLK_PERIOD = 4;
  localparam int RESET_CYCLES = 12;
  localparam int MAX_NODES = tlca_pkg::DEFAULT_MAX_NODES;
  localparam int RUN_LIMIT = 2_000_000;
  localparam int STALL_CYCLES = 400;
  localparam int NODE_W = tlca_pkg::NODE_W;
  localparam int MODE_W = tlca_pkg::MODE_W;
  localparam int COUNT_W = tlca_pkg::COUNT_W;

  // the one mode code the block ignores
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  typedef enum int {SHAPE_RANDOM, SHAPE_CHAIN, SHAPE_BUSH} tree_shape_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we;
  logic [COUNT_W-1:0] cfg_wdata;

  tlca_item_if item_if ();
  tlca_result_if result_if ();

  tree_lowest_common_ancestor #(
    .MAX_NODES(MAX_NODES)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .item(item_if),
    .result(result_if),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // predictor state: own copy of both tables and of node_count
  logic [NODE_W-1:0] tree_parent [0:MAX_NODES-1];
  logic [NODE_W-1:0] tree_depth [0:MAX_NODES-1];
  logic [COUNT_W-1:0] node_count_cfg = 11'd1;

  logic [NODE_W-1:0] ancestor_due [$];   // ancestors still owed by the block
  int mismatches = 0;
  int items_sent = 0;
  int tail_cycles = 0;   // rough busy time of the last accepted item
  int cycle_count = 0;
  int hold_req = 0;      // stall request picked up by the result side
  int hold_left = 0;
  bit gaps_on = 1'b1;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // node_count clamped to 1..MAX_NODES
  function automatic int nodes_in_use();
    if (node_count_cfg < 1) return 1;
    if (node_count_cfg > MAX_NODES) return MAX_NODES;
    return int'(node_count_cfg);
  endfunction

  // distance to root for every node in use; returns an estimate of build time
  function automatic int refresh_depths();
    int n;
    int x;
    int steps;
    int cost;
    bit reached;
    n = nodes_in_use();
    cost = 0;
    for (int i = 0; i < n; i++) begin
      x = i;
      steps = 0;
      reached = 1'b1;
      while (x != 0) begin
        // chain leaves the nodes in use or runs too long: unreachable
        if (x >= n || steps >= n) begin
          reached = 1'b0;
          break;
        end
        x = int'(tree_parent[x]);
        steps++;
      end
      tree_depth[i] = reached ? NODE_W'(steps) : '0;
      cost += 2 * steps + 1;
    end
    return cost;
  endfunction

  // climb the deeper node (second one on a tie) until both meet
  function automatic logic [NODE_W-1:0] climb_to_ancestor(input logic [NODE_W-1:0] u,
                                                          input logic [NODE_W-1:0] v,
                                                          output int steps);
    steps = 0;
    while (steps < 2 * MAX_NODES && u != v) begin
      if (tree_depth[u] > tree_depth[v]) u = tree_parent[u];
      else v = tree_parent[v];
      steps++;
    end
    // no meeting within the step budget gives root
    return (u == v) ? u : '0;
  endfunction

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  // offer one item, wait for the transfer, then update the predictor
  task automatic send_item(input logic [MODE_W-1:0] mode, input logic [NODE_W-1:0] a,
                           input logic [NODE_W-1:0] b);
    int steps;
    logic [NODE_W-1:0] want;
    while (gaps_on && $urandom_range(0, 99) < 8) begin
      item_if.valid <= 1'b0;
      @(posedge clk);
    end
    item_if.valid <= 1'b1;
    item_if.mode <= mode;
    item_if.node_a <= a;
    item_if.node_b <= b;
    @(posedge clk);
    while (!item_if.ready) @(posedge clk);
    // transfer taken at this edge
    case (mode)
      tlca_pkg::MODE_LOAD: begin
        tree_parent[b] = a;
        tail_cycles = 4;
      end
      tlca_pkg::MODE_BUILD: begin
        tail_cycles = refresh_depths() + 8;
      end
      tlca_pkg::MODE_QUERY: begin
        want = climb_to_ancestor(a, b, steps);
        ancestor_due = {ancestor_due, want};
        tail_cycles = 2 * steps + 8;
      end
      default: begin
        tail_cycles = 4;
      end
    endcase
    if (mode != MODE_SPARE) items_sent++;
  endtask

  // only while idle: all ancestors in, then time for a trailing build
  task automatic write_node_count(input logic [COUNT_W-1:0] value);
    item_if.valid <= 1'b0;
    while (ancestor_due.size() != 0) @(posedge clk);
    repeat (2 * tail_cycles + 16) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    node_count_cfg = value;
  endtask

  // well-formed tree over nodes 0..n-1 on shuffled labels, root 0
  task automatic grow_tree(input int n);
    int order [$];
    int k;
    int j;
    int tmp;
    tree_shape_t shape;
    logic [NODE_W-1:0] up;
    shape = tree_shape_t'($urandom_range(0, 2));
    for (k = 1; k < n; k++) order = {order, k};
    for (k = order.size() - 1; k > 0; k--) begin
      j = $urandom_range(0, k);
      tmp = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end
    for (k = 0; k < order.size(); k++) begin
      if (k == 0) begin
        up = '0;
      end else begin
        case (shape)
          // one long path, the deepest climbs
          SHAPE_CHAIN: up = NODE_W'(order[k-1]);
          // a few wide levels, many equal depths
          SHAPE_BUSH: up = ($urandom_range(0, 3) == 0) ? '0
                                                       : NODE_W'(order[$urandom_range(0, (k < 3) ? k - 1 : 2)]);
          default: up = ($urandom_range(0, k) == 0) ? '0 : NODE_W'(order[$urandom_range(0, k - 1)]);
        endcase
      end
      send_item(tlca_pkg::MODE_LOAD, up, NODE_W'(order[k]));
    end
  endtask

  // query two nodes of the current tree, sometimes the same node twice
  task automatic ask_about_tree(input int n);
    logic [NODE_W-1:0] a;
    logic [NODE_W-1:0] b;
    a = NODE_W'($urandom_range(0, n - 1));
    b = ($urandom_range(0, 7) == 0) ? a : NODE_W'($urandom_range(0, n - 1));
    send_item(tlca_pkg::MODE_QUERY, a, b);
  endtask

  // any item with any fields, ignoring the current tree
  task automatic send_noise();
    case ($urandom_range(0, 3))
      0: send_item(MODE_SPARE, NODE_W'($urandom), NODE_W'($urandom));
      1: send_item(tlca_pkg::MODE_LOAD, NODE_W'($urandom), NODE_W'($urandom));
      2: send_item(tlca_pkg::MODE_BUILD, NODE_W'($urandom), NODE_W'($urandom));
      default: send_item(tlca_pkg::MODE_QUERY, NODE_W'($urandom), NODE_W'($urandom));
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // result side: ready with random gaps or a long hold, and the checker
  // ---------------------------------------------------------------------------

  task automatic flag_mismatch(input string what, input logic [NODE_W-1:0] want,
                               input logic [NODE_W-1:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch, %s: expected ancestor %0d, got %0d (cycle %0d)",
               what, want, got, cycle_count);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      result_if.ready <= 1'b0;
    end else begin
      if (result_if.valid && result_if.ready) begin
        if (ancestor_due.size() == 0) begin
          flag_mismatch("transfer with nothing owed", 'x, result_if.ancestor);
        end else if (result_if.ancestor !== ancestor_due[0]) begin
          flag_mismatch("wrong ancestor", ancestor_due.pop_front(), result_if.ancestor);
        end else begin
          void'(ancestor_due.pop_front());
        end
      end
      // a requested hold overrides random idling
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= !(gaps_on && $urandom_range(0, 99) < 8);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= RUN_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tree_lowest_common_ancestor_tb NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // every table entry written at least once: heap-shaped tree over all nodes, then a
  // full build, so no later read can touch an unwritten entry
  task automatic test_fill_tables();
    // build at the reset node_count only touches the root
    send_item(tlca_pkg::MODE_BUILD, '0, '0);
    write_node_count(11'd1024);
    for (int i = 0; i < MAX_NODES; i++)
      send_item(tlca_pkg::MODE_LOAD, (i == 0) ? '0 : NODE_W'((i - 1) >> 1), NODE_W'(i));
    send_item(tlca_pkg::MODE_BUILD, '1, '1);
  endtask

  // field extremes on the full heap, siblings, ancestor pairs, spare mode
  task automatic test_directed_queries();
    send_item(tlca_pkg::MODE_QUERY, '0, '0);
    send_item(tlca_pkg::MODE_QUERY, 10'd1023, 10'd1022);
    send_item(tlca_pkg::MODE_QUERY, 10'd1023, 10'd7);
    send_item(tlca_pkg::MODE_QUERY, '0, 10'd1023);
    send_item(tlca_pkg::MODE_QUERY, 10'd1021, 10'd1022);
    send_item(MODE_SPARE, '1, '1);
  endtask

  // node_count of zero acts as one, above the table acts as the table size
  task automatic test_node_count_limits();
    write_node_count(11'd0);
    send_item(tlca_pkg::MODE_BUILD, '0, '0);
    send_item(tlca_pkg::MODE_QUERY, 10'd1022, 10'd1023);
    write_node_count(11'd2047);
    // move node 1023 under node 1, then rebuild everything
    send_item(tlca_pkg::MODE_LOAD, 10'd1, 10'd1023);
    send_item(tlca_pkg::MODE_BUILD, '0, '0);
    send_item(tlca_pkg::MODE_QUERY, 10'd1023, 10'd4);
    write_node_count(11'd1025);
    send_item(tlca_pkg::MODE_BUILD, '0, '0);
    send_item(tlca_pkg::MODE_QUERY, 10'd1000, 10'd999);
  endtask

  // parent loops, a parent outside the nodes in use, and a query that
  // never meets within the step budget
  task automatic test_unreachable_nodes();
    write_node_count(11'd8);
    send_item(tlca_pkg::MODE_LOAD, 10'd2, 10'd1);
    send_item(tlca_pkg::MODE_LOAD, 10'd1, 10'd2);
    send_item(tlca_pkg::MODE_LOAD, 10'd4, 10'd3);
    send_item(tlca_pkg::MODE_LOAD, 10'd3, 10'd4);
    send_item(tlca_pkg::MODE_LOAD, 10'd0, 10'd5);
    send_item(tlca_pkg::MODE_LOAD, 10'd5, 10'd6);
    send_item(tlca_pkg::MODE_LOAD, 10'd900, 10'd7);
    send_item(tlca_pkg::MODE_BUILD, '0, '0);
    send_item(tlca_pkg::MODE_QUERY, 10'd6, 10'd5);
    send_item(tlca_pkg::MODE_QUERY, 10'd2, 10'd1);
    // two separate loops, all depths zero: never meet, so the step bound gives root
    send_item(tlca_pkg::MODE_QUERY, 10'd1, 10'd3);
    send_item(tlca_pkg::MODE_QUERY, 10'd7, 10'd7);
  endtask

  // long stretch without idling on either side
  task automatic test_back_to_back();
    gaps_on = 1'b0;
    write_node_count(11'd24);
    grow_tree(24);
    send_item(tlca_pkg::MODE_BUILD, '0, '0);
    repeat (30) ask_about_tree(24);
    gaps_on = 1'b1;
  endtask

  // result side holds off while queries keep coming, input must stall
  task automatic test_output_stall();
    hold_req = STALL_CYCLES;
    repeat (10) ask_about_tree(24);
  endtask

  // random trees with random queries, some noise and some missing builds
  task automatic test_random_trees();
    int n;
    int first;
    int pick;
    first = items_sent;
    while (items_sent - first < 100) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) write_node_count(COUNT_W'($urandom_range(0, 1)));
      else if (pick == 1) write_node_count(11'd2);
      else write_node_count(COUNT_W'($urandom_range(3, 33)));
      n = nodes_in_use();
      grow_tree(n);
      // now and then the queries run on stale depths
      if ($urandom_range(0, 9) != 0)
        send_item(tlca_pkg::MODE_BUILD, NODE_W'($urandom), NODE_W'($urandom));
      repeat ($urandom_range(3, 12)) begin
        if ($urandom_range(0, 99) < 15) send_noise();
        else ask_about_tree(n);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    item_if.valid <= 1'b0;
    item_if.mode <= tlca_pkg::MODE_LOAD;
    item_if.node_a <= '0;
    item_if.node_b <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_fill_tables();
    test_directed_queries();
    test_node_count_limits();
    test_unreachable_nodes();
    test_back_to_back();
    test_output_stall();
    test_random_trees();

    // drain, then leave room for a trailing build or a stray transfer
    item_if.valid <= 1'b0;
    while (ancestor_due.size() != 0) @(posedge clk);
    repeat (2 * tail_cycles + 32) @(posedge clk);
    if (mismatches == 0 && ancestor_due.size() == 0)
      $display("tree_lowest_common_ancestor_tb OK");
    else
      $display("tree_lowest_common_ancestor_tb NOT OK");
    $finish;
  end

endmodule
